// ----- rtl/ik_chain_follow_core_defines.svh -----
// ----------------------------------------------------------------------------
// ik_chain_follow_core_defines
// Assertion macros shared by the joint chain core.
// ----------------------------------------------------------------------------
`ifndef IK_CHAIN_FOLLOW_CORE_DEFINES_SVH
`define IK_CHAIN_FOLLOW_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IKCF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ik_chain_follow_core: assertion failed");

// Next-cycle implication, disabled during reset.
`define IKCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ik_chain_follow_core: assertion failed");

`endif

// ----- rtl/ikcf_pkg.sv -----
// ----------------------------------------------------------------------------
// ikcf_pkg
// Types and constants of the joint chain core.
// ----------------------------------------------------------------------------
package ikcf_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int INDEX_W    = 6;
  localparam int COUNT_W    = 7;

  localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_JOINT_COUNT = 1'b1;

  // Shift commands for the row of joint cells.
  typedef struct packed {
    logic shift_dn;
    logic shift_up;
  } ring_ctl_t;

endpackage

// ----- rtl/ikcf_cell.sv -----
// ----------------------------------------------------------------------------
// ikcf_cell
// One joint of the chain; shifts toward either neighbor.
// ----------------------------------------------------------------------------
module ikcf_cell #(
  parameter int WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  ikcf_pkg::ring_ctl_t ctl,
  input  logic [WIDTH-1:0]   from_up,
  input  logic [WIDTH-1:0]   from_dn,
  output logic [WIDTH-1:0]   value
);
  import ikcf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (ctl.shift_dn) begin
      value <= from_up;
    end else if (ctl.shift_up) begin
      value <= from_dn;
    end
  end

endmodule

// ----- rtl/ikcf_isqrt.sv -----
// ----------------------------------------------------------------------------
// ikcf_isqrt
// Integer square root, rounded down, one result bit per cycle.
// ----------------------------------------------------------------------------
module ikcf_isqrt #(
  parameter int W = 26
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2*W-1:0] radicand,
  output logic           done,
  output logic [W-1:0]   root
);
  import ikcf_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [2*W-1:0] val;
  logic [W:0]     rem;
  logic [W-1:0]   rt;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [W+2:0]   sh;
  logic [W+2:0]   trial;

  assign sh    = {rem, val[2*W-1 -: 2]};
  assign trial = {1'b0, rt, 2'b01};
  assign root  = rt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val <= radicand;
      rem <= '0;
      rt  <= '0;
    end else if (busy) begin
      val <= val << 2;
      if (sh >= trial) begin
        rem <= (W+1)'(sh - trial);
        rt  <= {rt[W-2:0], 1'b1};
      end else begin
        rem <= (W+1)'(sh);
        rt  <= {rt[W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/ikcf_div.sv -----
// ----------------------------------------------------------------------------
// ikcf_div
// Restoring divider, one quotient bit per cycle, quotient below 2^(R+1).
// ----------------------------------------------------------------------------
module ikcf_div #(
  parameter int R = 26,
  parameter int N = 52
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [R-1:0] divisor,
  output logic         done,
  output logic [R:0]   quotient
);
  import ikcf_pkg::*;

  localparam int CW = $clog2(R + 2);

  logic [R-1:0]  rem;
  logic [R:0]    dv;
  logic [R-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [R:0]    sh;

  assign sh = {rem, dv[R]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(R + 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The upper dividend bits are known to be below the divisor, so only
  // R+1 quotient bits are developed.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= R'(dividend[N-1:R+1]);
      dv       <= dividend[R:0];
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      dv <= dv << 1;
      if (sh >= {1'b0, dsr}) begin
        rem      <= R'(sh - {1'b0, dsr});
        quotient <= {quotient[R-1:0], 1'b1};
      end else begin
        rem      <= sh[R-1:0];
        quotient <= {quotient[R-1:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/ik_chain_follow_core.sv -----
// ----------------------------------------------------------------------------
// ik_chain_follow_core
// 2D joint chain: direct joint writes or a forward reaching pass to a target.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// in        sink       in_valid/in_stall   joint_index, pos_x, pos_y
// out       source     out_valid/out_stall out_index, out_x, out_y,
//                                          range_error, last_joint
// cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transaction at a time; a direct write or an out-of-range index makes
// one full turn of the joint row, reporting as it goes. A chain drag first
// seeks the row to the last joint in use, then updates each earlier joint in
// turn (the divide is skipped on a zero direction) and realigns the row.
// Reset clears all joints to zero, chain_mode to 0 and joint_count to 2.
// A stalled output holds the joint row until the result is taken.
module ik_chain_follow_core #(
  parameter int MAX_JOINTS = 64,
  parameter int COORD_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ikcf_pkg::INDEX_W-1:0]     joint_index,
  input  logic signed [COORD_BITS-1:0]     pos_x,
  input  logic signed [COORD_BITS-1:0]     pos_y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ikcf_pkg::INDEX_W-1:0]     out_index,
  output logic signed [COORD_BITS-1:0]     out_x,
  output logic signed [COORD_BITS-1:0]     out_y,
  output logic                             range_error,
  output logic                             last_joint,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ikcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ikcf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ikcf_pkg::*;
  `include "ik_chain_follow_core_defines.svh"

  localparam int C  = COORD_BITS;
  localparam int D  = C + 1;
  localparam int R  = C + 2;
  localparam int N  = D + R + 1;
  localparam int W  = R + 3;
  localparam int KW = $clog2(MAX_JOINTS);

  localparam logic signed [W-1:0] CMAX = W'((64'sd1 <<< (C - 1)) - 64'sd1);
  localparam logic signed [W-1:0] CMIN = -CMAX - W'(1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SEEK  = 4'd1;
  localparam logic [3:0] ST_HEAD  = 4'd2;
  localparam logic [3:0] ST_PREP  = 4'd3;
  localparam logic [3:0] ST_SQ    = 4'd4;
  localparam logic [3:0] ST_ROOT  = 4'd5;
  localparam logic [3:0] ST_RWAIT = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_DGO   = 4'd8;
  localparam logic [3:0] ST_DWAIT = 4'd9;
  localparam logic [3:0] ST_UPD   = 4'd10;
  localparam logic [3:0] ST_ALIGN = 4'd11;
  localparam logic [3:0] ST_EMIT  = 4'd12;

  logic [3:0]          state;
  logic                chain_mode;
  logic [COUNT_W-1:0]  joint_count;
  logic [COUNT_W-1:0]  n_eff;

  logic [INDEX_W-1:0]  idx_r;
  logic signed [C-1:0] px_r, py_r;
  logic                err_r;
  logic [KW-1:0]       j;
  logic [KW-1:0]       k;

  logic signed [C-1:0] ox, oy, tx, ty, cx_r, cy_r;
  logic [D-1:0]        ex, ey, dx, dy;
  logic [D-1:0]        mdx, mdy;
  logic                sdx, sdy;
  logic [2*D-1:0]      sq_ex, sq_ey, sq_dx, sq_dy;
  logic [R-1:0]        len, m;
  logic [N-1:0]        prod_x, prod_y;
  logic [R:0]          qx, qy;

  logic [2*C-1:0]      cells [MAX_JOINTS];
  logic [2*C-1:0]      head_val;
  ring_ctl_t           ctl;

  logic signed [C-1:0] v0x, v0y;
  logic                root_done_a, root_done_b;
  logic [R-1:0]        root_a, root_b;
  logic                div_done_x, div_done_y;
  logic [R:0]          quot_x, quot_y;
  logic [D-1:0]        mex, mey, mdx_c, mdy_c;
  logic signed [W-1:0] offx_w, offy_w, newx_w, newy_w;
  logic signed [C-1:0] newx, newy;
  logic                k_in_range, out_free, wr_hit, emit_step;
  logic                quot_in_bound;

  assign v0x = cells[0][2*C-1:C];
  assign v0y = cells[0][C-1:0];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  always_comb begin
    if (joint_count < COUNT_W'(2)) begin
      n_eff = COUNT_W'(2);
    end else if (joint_count > COUNT_W'(MAX_JOINTS)) begin
      n_eff = COUNT_W'(MAX_JOINTS);
    end else begin
      n_eff = joint_count;
    end
  end

  assign k_in_range = COUNT_W'(k) < n_eff;
  assign out_free   = !out_valid || !out_stall;
  assign wr_hit     = !err_r && !chain_mode && (COUNT_W'(k) == COUNT_W'(idx_r));
  assign emit_step  = (state == ST_EMIT) && (!k_in_range || out_free);

  // Magnitudes of the stored differences.
  assign mex   = ex[D-1] ? (~ex + D'(1)) : ex;
  assign mey   = ey[D-1] ? (~ey + D'(1)) : ey;
  assign mdx_c = dx[D-1] ? (~dx + D'(1)) : dx;
  assign mdy_c = dy[D-1] ? (~dy + D'(1)) : dy;

  // New joint: target minus the signed, rounded offset, saturated.
  assign offx_w = sdx ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
  assign offy_w = sdy ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
  assign newx_w = {{(W-C){tx[C-1]}}, tx} - offx_w;
  assign newy_w = {{(W-C){ty[C-1]}}, ty} - offy_w;

  always_comb begin
    if (newx_w > CMAX) begin
      newx = CMAX[C-1:0];
    end else if (newx_w < CMIN) begin
      newx = CMIN[C-1:0];
    end else begin
      newx = newx_w[C-1:0];
    end
    if (newy_w > CMAX) begin
      newy = CMAX[C-1:0];
    end else if (newy_w < CMIN) begin
      newy = CMIN[C-1:0];
    end else begin
      newy = newy_w[C-1:0];
    end
  end

  // The head cell's outgoing value may be replaced as the row shifts.
  always_comb begin
    head_val     = cells[0];
    ctl.shift_dn = 1'b0;
    ctl.shift_up = 1'b0;
    unique case (state)
      ST_SEEK, ST_ALIGN: begin
        ctl.shift_dn = 1'b1;
      end
      ST_HEAD: begin
        head_val     = {px_r, py_r};
        ctl.shift_up = 1'b1;
      end
      ST_UPD: begin
        head_val     = {newx, newy};
        ctl.shift_up = 1'b1;
      end
      ST_EMIT: begin
        if (wr_hit) begin
          head_val = {px_r, py_r};
        end
        ctl.shift_dn = emit_step;
      end
      default: begin
        head_val = cells[0];
      end
    endcase
  end

  for (genvar i = 0; i < MAX_JOINTS; i++) begin : g_cell
    logic [2*C-1:0] up_in, dn_in;
    if (i == MAX_JOINTS - 1) begin : g_top
      assign up_in = head_val;
    end else begin : g_mid
      assign up_in = cells[i+1];
    end
    if (i == 0) begin : g_wrap
      assign dn_in = cells[MAX_JOINTS-1];
    end else if (i == 1) begin : g_next
      assign dn_in = head_val;
    end else begin : g_rest
      assign dn_in = cells[i-1];
    end
    ikcf_cell #(.WIDTH(2 * C)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .from_up (up_in),
      .from_dn (dn_in),
      .value   (cells[i])
    );
  end

  ikcf_isqrt #(.W(R)) u_sqrt_len (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_ROOT),
    .radicand ((2*R)'({1'b0, sq_ex} + {1'b0, sq_ey})),
    .done     (root_done_a),
    .root     (root_a)
  );

  ikcf_isqrt #(.W(R)) u_sqrt_dir (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_ROOT),
    .radicand ((2*R)'({1'b0, sq_dx} + {1'b0, sq_dy})),
    .done     (root_done_b),
    .root     (root_b)
  );

  ikcf_div #(.R(R), .N(N)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DGO),
    .dividend (prod_x),
    .divisor  (m),
    .done     (div_done_x),
    .quotient (quot_x)
  );

  ikcf_div #(.R(R), .N(N)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DGO),
    .dividend (prod_y),
    .divisor  (m),
    .done     (div_done_y),
    .quotient (quot_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_mode  <= 1'b0;
      joint_count <= COUNT_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHAIN_MODE:  chain_mode  <= cfg_data[0];
        REG_JOINT_COUNT: joint_count <= cfg_data;
        default:         chain_mode  <= chain_mode;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      j     <= '0;
      k     <= '0;
      err_r <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            err_r <= (COUNT_W'(joint_index) >= n_eff);
            j     <= '0;
            k     <= '0;
            if ((COUNT_W'(joint_index) < n_eff) && chain_mode) begin
              state <= ST_SEEK;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_SEEK: begin
          j <= j + 1'b1;
          if (COUNT_W'(j) + COUNT_W'(2) == n_eff) begin
            state <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          j     <= KW'(n_eff - COUNT_W'(2));
          state <= ST_PREP;
        end
        ST_PREP:  state <= ST_SQ;
        ST_SQ:    state <= ST_ROOT;
        ST_ROOT:  state <= ST_RWAIT;
        ST_RWAIT: begin
          if (root_done_a) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= (m == '0) ? ST_UPD : ST_DGO;
        end
        ST_DGO:   state <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done_x) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (j == '0) begin
            state <= ST_ALIGN;
          end else begin
            j     <= j - 1'b1;
            state <= ST_PREP;
          end
        end
        ST_ALIGN: begin
          k     <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_step) begin
            k <= k + 1'b1;
            if (k == KW'(MAX_JOINTS - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      idx_r <= joint_index;
      px_r  <= pos_x;
      py_r  <= pos_y;
    end
    if (state == ST_HEAD) begin
      ox <= v0x;
      oy <= v0y;
      tx <= px_r;
      ty <= py_r;
    end
    if (state == ST_PREP) begin
      cx_r <= v0x;
      cy_r <= v0y;
      ex   <= {v0x[C-1], v0x} - {ox[C-1], ox};
      ey   <= {v0y[C-1], v0y} - {oy[C-1], oy};
      dx   <= {tx[C-1], tx} - {v0x[C-1], v0x};
      dy   <= {ty[C-1], ty} - {v0y[C-1], v0y};
    end
    if (state == ST_SQ) begin
      sq_ex <= (2*D)'(mex) * (2*D)'(mex);
      sq_ey <= (2*D)'(mey) * (2*D)'(mey);
      sq_dx <= (2*D)'(mdx_c) * (2*D)'(mdx_c);
      sq_dy <= (2*D)'(mdy_c) * (2*D)'(mdy_c);
      mdx   <= mdx_c;
      mdy   <= mdy_c;
      sdx   <= dx[D-1];
      sdy   <= dy[D-1];
    end
    if (state == ST_RWAIT && root_done_a) begin
      len <= root_a;
      m   <= root_b;
    end
    if (state == ST_MUL) begin
      prod_x <= N'(mdx) * N'(len) + N'(m >> 1);
      prod_y <= N'(mdy) * N'(len) + N'(m >> 1);
      qx     <= '0;
      qy     <= '0;
    end
    if (state == ST_DWAIT && div_done_x) begin
      qx <= quot_x;
      qy <= quot_y;
    end
    if (state == ST_UPD) begin
      ox <= cx_r;
      oy <= cy_r;
      tx <= newx;
      ty <= newy;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_step && k_in_range) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_step && k_in_range) begin
      out_index   <= INDEX_W'(k);
      out_x       <= head_val[2*C-1:C];
      out_y       <= head_val[C-1:0];
      range_error <= err_r;
      last_joint  <= (COUNT_W'(k) + COUNT_W'(1) == n_eff);
    end
  end

  assign quot_in_bound = ({1'b0, quot_x} <= ({2'b00, len} + (R+2)'(1))) &&
                         ({1'b0, quot_y} <= ({2'b00, len} + (R+2)'(1)));

  `IKCF_ASSERT_NOW(a_ring_dir, clk, rst, 1'b1, $onehot0({ctl.shift_dn, ctl.shift_up}))
  `IKCF_ASSERT_NEXT(a_busy_after_in, clk, rst, in_valid && !in_stall, state != ST_IDLE)
  `IKCF_ASSERT_NOW(a_quot_bound, clk, rst, state == ST_DWAIT && div_done_x, quot_in_bound)
  `IKCF_ASSERT_NOW(a_sqrt_lockstep, clk, rst, 1'b1, root_done_a == root_done_b)
  `IKCF_ASSERT_NOW(a_div_lockstep, clk, rst, 1'b1, div_done_x == div_done_y)

endmodule

// ----- tb/tb_ik_chain_follow_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ik_chain_follow_core
// Self-checking testbench for the joint chain core. Direct joint writes and
// chain drags are predicted in the bench and every reported joint is checked
// in order against the prediction, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_ik_chain_follow_core;
  import ikcf_pkg::*;

  localparam int MAX_JOINTS = 64;
  localparam int COORD_BITS = 24;
  localparam int SETTLE_CYCLES = 2 * MAX_JOINTS + 20;
  localparam int IDLE_LIMIT = 40000;

  typedef struct {
    logic [INDEX_W-1:0]    index;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  err;
    logic                  last;
  } joint_report_t;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitpos;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v = v - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned vec_length(longint dx, longint dy);
    longint unsigned ax, ay;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    return int_sqrt(ax * ax + ay * ay);
  endfunction

  // Rounds half away from zero.
  function automatic longint scaled_offset(longint dc, longint unsigned seg,
                                           longint unsigned span);
    longint unsigned q;
    q = ((dc < 0 ? -dc : dc) * seg + (span >> 1)) / span;
    return dc < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_coord(longint v);
    longint hi;
    hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  class chain_scoreboard;
    longint jx[MAX_JOINTS];
    longint jy[MAX_JOINTS];
    bit drag_mode;
    bit [COUNT_W-1:0] count_reg;
    joint_report_t expected_q[$];
    int mismatches;
    int results_seen;
    int items_seen;
    int drags_seen;

    function new();
      foreach (jx[i]) begin
        jx[i] = 0;
        jy[i] = 0;
      end
      drag_mode = 0;
      count_reg = 2;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_CHAIN_MODE) drag_mode = data[0];
      else if (idx == REG_JOINT_COUNT) count_reg = data;
    endfunction

    function int joints_in_use();
      if (count_reg < 2) return 2;
      if (count_reg > MAX_JOINTS) return MAX_JOINTS;
      return count_reg;
    endfunction

    function void note_input(logic [INDEX_W-1:0] idx, logic signed [COORD_BITS-1:0] px,
                             logic signed [COORD_BITS-1:0] py);
      int n;
      bit err;
      longint ox, oy, cx, cy, tx, ty, dx, dy, offx, offy;
      longint unsigned seg, span;
      joint_report_t r;
      n = joints_in_use();
      err = idx >= n;
      items_seen++;
      if (!err && !drag_mode) begin
        jx[idx] = px;
        jy[idx] = py;
      end else if (!err) begin
        drags_seen++;
        ox = jx[n-1];
        oy = jy[n-1];
        jx[n-1] = px;
        jy[n-1] = py;
        for (int j = n - 2; j >= 0; j--) begin
          cx = jx[j];
          cy = jy[j];
          tx = jx[j+1];
          ty = jy[j+1];
          seg = vec_length(cx - ox, cy - oy);
          dx = tx - cx;
          dy = ty - cy;
          span = vec_length(dx, dy);
          offx = 0;
          offy = 0;
          if (span != 0) begin
            offx = scaled_offset(dx, seg, span);
            offy = scaled_offset(dy, seg, span);
          end
          ox = cx;
          oy = cy;
          jx[j] = clamp_coord(tx - offx);
          jy[j] = clamp_coord(ty - offy);
        end
      end
      for (int k = 0; k < n; k++) begin
        r.index = k;
        r.x = jx[k][COORD_BITS-1:0];
        r.y = jy[k][COORD_BITS-1:0];
        r.err = err;
        r.last = (k == n - 1);
        expected_q = {expected_q, r};
      end
    endfunction

    function void check_result(joint_report_t got);
      joint_report_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected joint report index %0d x %h y %h", got.index,
                   got.x, got.y);
        return;
      end
      want = expected_q.pop_front();
      if (got.index !== want.index || got.x !== want.x || got.y !== want.y ||
          got.err !== want.err || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: joint report mismatch: expected idx %0d x %h y %h err %b last %b",
                   want.index, want.x, want.y, want.err, want.last);
          $display("       got idx %0d x %h y %h err %b last %b",
                   got.index, got.x, got.y, got.err, got.last);
        end
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall;
  logic [INDEX_W-1:0] joint_index;
  logic signed [COORD_BITS-1:0] pos_x, pos_y;
  logic out_valid, out_stall;
  logic [INDEX_W-1:0] out_index;
  logic signed [COORD_BITS-1:0] out_x, out_y;
  logic range_error, last_joint;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  chain_scoreboard sb = new();
  bit calm;
  bit long_hold_req;
  int idle_cycles;

  ik_chain_follow_core #(.MAX_JOINTS(MAX_JOINTS), .COORD_BITS(COORD_BITS)) dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{out_index, out_x, out_y, range_error, last_joint});
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("ik_chain_follow_core test failed");
      $finish;
    end
  end

  // Result side: random hold-off before each joint report, one long hold on request.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        n = 400;
      end else begin
        n = calm ? 0 : $urandom_range(0, 15);
      end
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_item(logic [INDEX_W-1:0] idx, logic [COORD_BITS-1:0] x,
                           logic [COORD_BITS-1:0] y);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    repeat (gap) @(negedge clk);
    in_valid <= 1;
    joint_index <= idx;
    pos_x <= x;
    pos_y <= y;
    do @(posedge clk); while (in_stall);
    sb.note_input(idx, x, y);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Drain all expected reports, then let the joint row finish its turn.
  task automatic settle();
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      1, 2: return COORD_BITS'($signed($urandom_range(0, 8191)) - 4096);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int cnt;
    rst = 1;
    in_valid = 0;
    joint_index = 0;
    pos_x = 0;
    pos_y = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    calm = 0;
    long_hold_req = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: reset settings, field extremes and out-of-range indexes.
    send_item(0, 24'h7FFFFF, 24'h800000);
    send_item(1, 24'h800000, 24'h7FFFFF);
    send_item(2, 24'h123456, 24'h654321);
    send_item(63, 0, 0);
    settle();
    write_cfg(REG_JOINT_COUNT, 64);
    send_item(63, 24'h7FFFFF, 24'h7FFFFF);
    send_item(0, 0, 0);
    settle();
    write_cfg(REG_JOINT_COUNT, 127);
    send_item(63, 24'h800000, 24'h800000);
    settle();
    write_cfg(REG_JOINT_COUNT, 0);
    send_item(1, 24'h000500, 24'h000500);
    send_item(2, 1, 1);
    settle();
    write_cfg(REG_JOINT_COUNT, 1);
    send_item(0, 24'h000500, 24'h000500);
    settle();
    // Chain drag: saturation at the extremes, zero-length direction, range error.
    write_cfg(REG_JOINT_COUNT, 4);
    send_item(2, 24'h7FFFF0, 24'h800010);
    send_item(3, 24'h000500, 24'h000500);
    settle();
    write_cfg(REG_CHAIN_MODE, 1);
    send_item(0, 24'h800000, 24'h7FFFFF);
    send_item(3, 24'h7FFFFF, 24'h800000);
    send_item(4, 24'h000100, 24'h000200);
    settle();
    write_cfg(REG_CHAIN_MODE, 0);
    for (int i = 0; i < 4; i++) send_item(INDEX_W'(i), 24'h000300, 24'h000300);
    settle();
    write_cfg(REG_CHAIN_MODE, 1);
    send_item(1, 24'h000300, 24'h000300);
    send_item(3, 24'h000340, 24'h0002C0);

    // Random phases, mostly short chains; one phase holds the result side long.
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      case ($urandom_range(0, 9))
        0: cnt = MAX_JOINTS;
        1: cnt = $urandom_range(0, 1) ? 127 : $urandom_range(0, 1);
        2: cnt = $urandom_range(9, 20);
        default: cnt = $urandom_range(2, 8);
      endcase
      if (ph == 9) cnt = MAX_JOINTS;
      write_cfg(REG_JOINT_COUNT, CFG_DATA_W'(cnt));
      write_cfg(REG_CHAIN_MODE, CFG_DATA_W'((ph % 3) != 0));
      calm = (ph == 4);
      if (ph == 2) long_hold_req = 1;
      for (int i = 0; i < (ph == 9 ? 6 : 28); i++) begin
        send_item(INDEX_W'($urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                    : $urandom_range(0, sb.joints_in_use() - 1)),
                  rand_coord(), rand_coord());
      end
    end

    settle();
    $display("Covered %0d transactions (%0d chain drags), %0d joint reports checked.",
             sb.items_seen, sb.drags_seen, sb.results_seen);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("ik_chain_follow_core test passed");
    else
      $display("ik_chain_follow_core test failed");
    $finish;
  end
endmodule
